>>> sv/ihex_pkg.sv
// shared types, constants and the hex digit decoder of the intel hex record parser
// no dependencies
package ihex_pkg;

	localparam logic [8:0] COUNT_MAX   = 9'd511;
	localparam logic [8:0] MIN_CHARS   = 9'd11;
	localparam logic [8:0] FRAME_BYTES = 9'd5;
	localparam int unsigned SEG_SHIFT  = 4;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;

	localparam logic [7:0] TYPE_EXT_SEG   = 8'd2;
	localparam logic [7:0] TYPE_START_SEG = 8'd3;
	localparam logic [7:0] TYPE_EXT_LIN   = 8'd4;
	localparam logic [7:0] TYPE_START_LIN = 8'd5;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_COLON  = 3'd1,
		ST_BAD_DIGIT = 3'd2,
		ST_SHORT_ODD = 3'd3,
		ST_LENGTH    = 3'd4,
		ST_CHECKSUM  = 3'd5,
		ST_BAD_TYPE  = 3'd6
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [16:0] byte_address;
		logic [7:0]  data_byte;
		logic [7:0]  record_type;
		logic [7:0]  record_length;
		status_t     status;
		logic [19:0] segment_base;
		logic [31:0] linear_base;
		logic [15:0] start_address;
	} result_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} nibble_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t r;
		r.bad   = 1'b0;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.value = 4'(c - 8'h57);
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> sv/ihex_line_proc.sv
// per-line parse state, base registers and next-state logic for one character
// depends on ihex_pkg
module ihex_line_proc
	import ihex_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] character,
	input  logic       line_end,
	output logic       res_valid,
	output result_t    res
);

	logic [8:0]  char_count_q, char_count_n;
	logic [3:0]  high_nibble_q, high_nibble_n;
	logic [7:0]  running_sum_q, running_sum_n;
	logic [7:0]  declared_length_q, declared_length_n;
	logic [15:0] load_address_q, load_address_n;
	logic [7:0]  type_byte_q, type_byte_n;
	logic [15:0] first_word_q, first_word_n;
	status_t     error_q, error_n;
	logic [19:0] segment_base_q, segment_base_n;
	logic [31:0] linear_base_q, linear_base_n;
	logic [15:0] start_address_q, start_address_n;

	nibble_t     nib;
	logic [3:0]  v;
	logic [8:0]  p;
	logic [7:0]  b;
	logic [7:0]  bi;
	logic [7:0]  off;
	logic        emit;
	logic [7:0]  dbyte;
	logic [16:0] daddr;
	logic [8:0]  len_chars;
	logic [8:0]  pair_count;
	status_t     stat;

	always_comb begin
		char_count_n      = char_count_q;
		high_nibble_n     = high_nibble_q;
		running_sum_n     = running_sum_q;
		declared_length_n = declared_length_q;
		load_address_n    = load_address_q;
		type_byte_n       = type_byte_q;
		first_word_n      = first_word_q;
		error_n           = error_q;
		segment_base_n    = segment_base_q;
		linear_base_n     = linear_base_q;
		start_address_n   = start_address_q;
		nib   = hex_nibble(character);
		v     = nib.bad ? 4'd0 : nib.value;
		p     = char_count_q - 9'd1;
		b     = {high_nibble_q, v};
		bi    = p[8:1];
		off   = bi - 8'd4;
		emit  = 1'b0;
		dbyte = b;
		daddr = {1'b0, load_address_q} + {9'd0, off};

		if (char_count_q == COUNT_MAX) begin
			if (error_q == ST_OK) error_n = ST_LENGTH;
		end else begin
			if (char_count_q == 9'd0) begin
				if (character != CHAR_COLON && error_q == ST_OK) error_n = ST_NO_COLON;
			end else begin
				if (nib.bad && error_q == ST_OK) error_n = ST_BAD_DIGIT;
				if (!p[0]) begin
					high_nibble_n = v;
				end else begin
					running_sum_n = running_sum_q + b;
					case (bi)
						8'd0: declared_length_n = b;
						8'd1: load_address_n[15:8] = b;
						8'd2: load_address_n[7:0] = b;
						8'd3: type_byte_n = b;
						default: begin
							if (off < declared_length_q) begin
								if (bi == 8'd4) first_word_n[15:8] = b;
								if (bi == 8'd5) first_word_n[7:0] = b;
								if (error_n == ST_OK) emit = 1'b1;
							end
						end
					endcase
				end
			end
			char_count_n = char_count_q + 9'd1;
		end

		len_chars  = char_count_n;
		pair_count = (len_chars - 9'd1) >> 1;
		stat       = error_n;
		if (line_end && stat == ST_OK) begin
			if (len_chars < MIN_CHARS || !len_chars[0]) begin
				stat = ST_SHORT_ODD;
			end else if ({1'b0, declared_length_n} + FRAME_BYTES != pair_count) begin
				stat = ST_LENGTH;
			end else if (running_sum_n != 8'd0) begin
				stat = ST_CHECKSUM;
			end else if (type_byte_n == TYPE_EXT_SEG) begin
				segment_base_n = {first_word_n, SEG_SHIFT'(0)};
			end else if (type_byte_n == TYPE_EXT_LIN) begin
				linear_base_n = {first_word_n, 16'd0};
			end else if (type_byte_n == TYPE_START_SEG || type_byte_n == TYPE_START_LIN) begin
				start_address_n = first_word_n;
			end else if (type_byte_n > TYPE_START_LIN) begin
				stat = ST_BAD_TYPE;
			end
		end

		res_valid         = line_end || emit;
		res.kind          = line_end;
		res.byte_address  = line_end ? {1'b0, load_address_n} : daddr;
		res.data_byte     = line_end ? 8'd0 : dbyte;
		res.record_type   = type_byte_n;
		res.record_length = declared_length_n;
		res.status        = line_end ? stat : ST_OK;
		res.segment_base  = segment_base_n;
		res.linear_base   = linear_base_n;
		res.start_address = start_address_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q      <= '0;
			high_nibble_q     <= '0;
			running_sum_q     <= '0;
			declared_length_q <= '0;
			load_address_q    <= '0;
			type_byte_q       <= '0;
			first_word_q      <= '0;
			error_q           <= ST_OK;
			segment_base_q    <= '0;
			linear_base_q     <= '0;
			start_address_q   <= '0;
		end else if (step) begin
			segment_base_q  <= segment_base_n;
			linear_base_q   <= linear_base_n;
			start_address_q <= start_address_n;
			if (line_end) begin
				char_count_q      <= '0;
				high_nibble_q     <= '0;
				running_sum_q     <= '0;
				declared_length_q <= '0;
				load_address_q    <= '0;
				type_byte_q       <= '0;
				first_word_q      <= '0;
				error_q           <= ST_OK;
			end else begin
				char_count_q      <= char_count_n;
				high_nibble_q     <= high_nibble_n;
				running_sum_q     <= running_sum_n;
				declared_length_q <= declared_length_n;
				load_address_q    <= load_address_n;
				type_byte_q       <= type_byte_n;
				first_word_q      <= first_word_n;
				error_q           <= error_n;
			end
		end
	end

endmodule

>>> sv/intel_hex_record_parser_top.sv
// Intel HEX record parser: takes one character per cycle while not stalled and returns at most
// one result per character, a data byte or an end-of-line status. A character passes the input
// register, then the result register, before its result shows; the line state updates on each step,
// so back-to-back characters run at one per clock whenever the output side is not stalled.
// depends on ihex_pkg and ihex_line_proc
module intel_hex_record_parser_top
	import ihex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [16:0] byte_address,
	output logic [7:0]  data_byte,
	output logic [7:0]  record_type,
	output logic [7:0]  record_length,
	output logic [2:0]  status,
	output logic [19:0] segment_base,
	output logic [31:0] linear_base,
	output logic [15:0] start_address
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       advance;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			last_s1 <= line_end;
		end
	end

	ihex_line_proc u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.character (char_s1),
		.line_end  (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign byte_address  = out_q.byte_address;
	assign data_byte     = out_q.data_byte;
	assign record_type   = out_q.record_type;
	assign record_length = out_q.record_length;
	assign status        = out_q.status;
	assign segment_base  = out_q.segment_base;
	assign linear_base   = out_q.linear_base;
	assign start_address = out_q.start_address;

endmodule
